// ===== rtl/pcs_pkg.sv =====
// Shared widths, item codes and parameter defaults for the path corridor splice block.
`timescale 1ns / 1ps

package pcs_pkg;

   // Fixed widths of the item fields
   localparam int FUNC_W     = 2;
   localparam int REF_PORT_W = 32;
   localparam int INDEX_W    = 6;
   localparam int LEN_W      = 7;

   // Parameter defaults
   localparam int PATH_DEPTH_DEF    = 64;
   localparam int VISITED_DEPTH_DEF = 16;
   localparam int REF_WIDTH_DEF     = 32;

   // Reset value of the path limit register
   localparam logic [LEN_W-1:0] PATH_LIMIT_RST = 7'd64;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PATH_APPEND  = 2'd0,
      FUNC_VISIT_APPEND = 2'd1,
      FUNC_SPLICE       = 2'd2,
      FUNC_CLEAR        = 2'd3
   } func_type;

endpackage

// ===== rtl/path_corridor_splice.sv =====
// Top level: path and visited stores in synchronous RAMs, splice sequencer and result output.
`timescale 1ns / 1ps
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------------
//  req     | in        | req_valid / req_stall | func, poly_ref
//  rsp     | out       | rsp_valid / rsp_stall | entry_ref, entry_index, path_length,
//          |           |                       | spliced, empty_path, dropped, last
//  csr     | in        | csr_wr_en             | path limit (7 bits)
//
//  Appends and clear are done in S_IDLE; req_stall is high for the whole splice.
//  A splice tests path entries from the top down, one visited compare per cycle. A hit
//  rebuilds the path through single RAM ports; after a read of the first entry the path
//  streams out an entry per cycle, and rsp_stall freezes the output entry in place.
//  Synchronous reset clears counts and drop flag and sets the limit to 64; RAMs keep data.

module path_corridor_splice #(
   parameter int PATH_DEPTH    = pcs_pkg::PATH_DEPTH_DEF,
   parameter int VISITED_DEPTH = pcs_pkg::VISITED_DEPTH_DEF,
   parameter int REF_WIDTH     = pcs_pkg::REF_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // item input
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [pcs_pkg::FUNC_W-1:0]       req_func,
   input  logic [pcs_pkg::REF_PORT_W-1:0]   req_poly_ref,
   // result output
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [pcs_pkg::REF_PORT_W-1:0]   rsp_entry_ref,
   output logic [pcs_pkg::INDEX_W-1:0]      rsp_entry_index,
   output logic [pcs_pkg::LEN_W-1:0]        rsp_path_length,
   output logic                             rsp_spliced,
   output logic                             rsp_empty_path,
   output logic                             rsp_dropped,
   output logic                             rsp_last,
   // path limit register
   input  logic                             csr_wr_en,
   input  logic [pcs_pkg::LEN_W-1:0]        csr_wr_data
);
   import pcs_pkg::*;

   // stored reference width: the item field is 32 bits, so never wider than that
   localparam int SW  = (REF_WIDTH < REF_PORT_W) ? REF_WIDTH : REF_PORT_W;
   localparam int PAW = $clog2(PATH_DEPTH);
   localparam int PCW = $clog2(PATH_DEPTH + 1);
   localparam int VAW = (VISITED_DEPTH > 1) ? $clog2(VISITED_DEPTH) : 1;
   localparam int VCW = $clog2(VISITED_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_FETCH,   // read path entry under test and first visited entry
      S_SCAN,    // compare against one visited entry a cycle
      S_CALC,    // work out visited and tail lengths
      S_SETUP,   // tail copy direction and start addresses
      S_TAIL,    // move the kept path tail into place
      S_VIS,     // write visited entries, newest first, to the front
      S_EFETCH,  // start of output
      S_EOUT     // result on the port
   } state_type;

   // ---------------------------------------------------------------------------------------
   // Memories: one write and one registered read port each
   // ---------------------------------------------------------------------------------------
   logic [SW-1:0]  pm_mem [PATH_DEPTH];
   logic [SW-1:0]  vm_mem [VISITED_DEPTH];

   logic           pm_we, pm_re, vm_we, vm_re;
   logic [PAW-1:0] pm_waddr, pm_raddr;
   logic [VAW-1:0] vm_waddr, vm_raddr;
   logic [SW-1:0]  pm_wdata, vm_wdata;
   logic [SW-1:0]  pm_rd_ff, vm_rd_ff;

   always_ff @(posedge clock) begin
      if (pm_we) begin
         pm_mem[pm_waddr] <= pm_wdata;
      end
      if (pm_re) begin
         pm_rd_ff <= pm_mem[pm_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (vm_we) begin
         vm_mem[vm_waddr] <= vm_wdata;
      end
      if (vm_re) begin
         vm_rd_ff <= vm_mem[vm_raddr];
      end
   end

   // ---------------------------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------------------------
   state_type        state_ff, state_in;
   logic [PCW-1:0]   pc_ff, pc_in;              // path count
   logic [VCW-1:0]   vc_ff, vc_in;              // visited count
   logic             drop_ff, drop_in;
   logic [LEN_W-1:0] limit_ff, limit_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // splice working registers
   logic [PAW-1:0]   pi_ff, pi_in;              // path index under test / match
   logic [VAW-1:0]   cj_ff, cj_in;              // visited index in vm_rd_ff / match
   logic [PCW-1:0]   req_ff, req_in;            // visited entries kept
   logic [PCW-1:0]   rest_ff, rest_in;          // path tail entries kept
   logic             back_ff, back_in;          // tail copied top-down
   logic [PAW-1:0]   src_ff, src_in;
   logic [PAW-1:0]   dst_ff, dst_in;
   logic [VAW-1:0]   vsrc_ff, vsrc_in;
   logic [PCW-1:0]   cnt_ff, cnt_in;
   logic             wpend_ff, wpend_in;

   // output payload
   logic [PAW-1:0]   k_ff, k_in;
   logic             spliced_ff, spliced_in;
   logic             empty_ff, empty_in;
   logic             drop_rpt_ff, drop_rpt_in;

   logic             req_take, rsp_take, rsp_is_last, hit, scan_end;
   logic [LEN_W-1:0] lim_w, reqa_w, reqc_w, tail_w, room_w, restc_w;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   assign rsp_is_last = empty_ff || ((PCW'(k_ff) + PCW'(1)) == pc_ff);
   assign hit         = (pm_rd_ff == vm_rd_ff);
   assign scan_end    = (VCW'(cj_ff) == (vc_ff - VCW'(1)));

   // lengths of the new path; all values stay at or below 64
   always_comb begin
      lim_w   = (limit_ff < LEN_W'(PATH_DEPTH)) ? limit_ff : LEN_W'(PATH_DEPTH);
      reqa_w  = LEN_W'(vc_ff) - LEN_W'(cj_ff);
      reqc_w  = (reqa_w < lim_w) ? reqa_w : lim_w;
      tail_w  = LEN_W'(pc_ff) - LEN_W'(pi_ff) - LEN_W'(1);
      room_w  = lim_w - reqc_w;
      restc_w = (tail_w < room_w) ? tail_w : room_w;
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      vc_in        = vc_ff;
      drop_in      = drop_ff;
      limit_in     = limit_ff;
      rsp_valid_in = rsp_valid_ff;
      pi_in        = pi_ff;
      cj_in        = cj_ff;
      req_in       = req_ff;
      rest_in      = rest_ff;
      back_in      = back_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      vsrc_in      = vsrc_ff;
      cnt_in       = cnt_ff;
      wpend_in     = wpend_ff;
      k_in         = k_ff;
      spliced_in   = spliced_ff;
      empty_in     = empty_ff;
      drop_rpt_in  = drop_rpt_ff;

      pm_we    = 1'b0;
      pm_re    = 1'b0;
      vm_we    = 1'b0;
      vm_re    = 1'b0;
      pm_waddr = dst_ff;
      pm_raddr = src_ff;
      vm_waddr = vc_ff[VAW-1:0];
      vm_raddr = vsrc_ff;
      pm_wdata = pm_rd_ff;
      vm_wdata = SW'(req_poly_ref);

      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               unique case (func_type'(req_func))
                  FUNC_PATH_APPEND: begin
                     if (pc_ff < PCW'(PATH_DEPTH)) begin
                        pm_we    = 1'b1;
                        pm_waddr = pc_ff[PAW-1:0];
                        pm_wdata = SW'(req_poly_ref);
                        pc_in    = pc_ff + PCW'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  FUNC_VISIT_APPEND: begin
                     if (vc_ff < VCW'(VISITED_DEPTH)) begin
                        vm_we = 1'b1;
                        vc_in = vc_ff + VCW'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  FUNC_SPLICE: begin
                     drop_rpt_in = drop_ff;
                     drop_in     = 1'b0;
                     spliced_in  = 1'b0;
                     if (pc_ff == '0 || vc_ff == '0) begin
                        state_in = S_EFETCH;
                     end else begin
                        pi_in    = PAW'(pc_ff - PCW'(1));
                        state_in = S_FETCH;
                     end
                  end
                  FUNC_CLEAR: begin
                     pc_in   = '0;
                     vc_in   = '0;
                     drop_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end

         S_FETCH: begin
            pm_re    = 1'b1;
            pm_raddr = pi_ff;
            vm_re    = 1'b1;
            vm_raddr = '0;
            cj_in    = '0;
            state_in = S_SCAN;
         end

         S_SCAN: begin
            if (hit) begin
               spliced_in = 1'b1;
               state_in   = S_CALC;
            end else if (scan_end) begin
               if (pi_ff == '0) begin
                  state_in = S_EFETCH;
               end else begin
                  pi_in    = pi_ff - PAW'(1);
                  state_in = S_FETCH;
               end
            end else begin
               vm_re    = 1'b1;
               vm_raddr = cj_ff + VAW'(1);
               cj_in    = cj_ff + VAW'(1);
            end
         end

         S_CALC: begin
            req_in   = PCW'(reqc_w);
            rest_in  = PCW'(restc_w);
            state_in = S_SETUP;
         end

         S_SETUP: begin
            // visited part longer than the space before the tail: copy the tail top-down
            back_in  = (LEN_W'(req_ff) > (LEN_W'(pi_ff) + LEN_W'(1)));
            if (LEN_W'(req_ff) > (LEN_W'(pi_ff) + LEN_W'(1))) begin
               src_in = PAW'(LEN_W'(pi_ff) + LEN_W'(rest_ff));
               dst_in = PAW'(LEN_W'(req_ff) + LEN_W'(rest_ff) - LEN_W'(1));
            end else begin
               src_in = pi_ff + PAW'(1);
               dst_in = req_ff[PAW-1:0];
            end
            cnt_in   = rest_ff;
            wpend_in = 1'b0;
            state_in = S_TAIL;
         end

         S_TAIL: begin
            if (wpend_ff) begin
               pm_we    = 1'b1;
               pm_waddr = dst_ff;
               pm_wdata = pm_rd_ff;
               dst_in   = back_ff ? (dst_ff - PAW'(1)) : (dst_ff + PAW'(1));
            end
            if (cnt_ff != '0) begin
               pm_re    = 1'b1;
               pm_raddr = src_ff;
               src_in   = back_ff ? (src_ff - PAW'(1)) : (src_ff + PAW'(1));
               cnt_in   = cnt_ff - PCW'(1);
               wpend_in = 1'b1;
            end else begin
               wpend_in = 1'b0;
            end
            if (cnt_ff == '0 && !wpend_ff) begin
               vsrc_in  = VAW'(vc_ff - VCW'(1));
               dst_in   = '0;
               cnt_in   = req_ff;
               wpend_in = 1'b0;
               state_in = S_VIS;
            end
         end

         S_VIS: begin
            if (wpend_ff) begin
               pm_we    = 1'b1;
               pm_waddr = dst_ff;
               pm_wdata = vm_rd_ff;
               dst_in   = dst_ff + PAW'(1);
            end
            if (cnt_ff != '0) begin
               vm_re    = 1'b1;
               vm_raddr = vsrc_ff;
               vsrc_in  = vsrc_ff - VAW'(1);
               cnt_in   = cnt_ff - PCW'(1);
               wpend_in = 1'b1;
            end else begin
               wpend_in = 1'b0;
            end
            if (cnt_ff == '0 && !wpend_ff) begin
               pc_in    = req_ff + rest_ff;
               state_in = S_EFETCH;
            end
         end

         S_EFETCH: begin
            vc_in        = '0;
            k_in         = '0;
            empty_in     = (pc_ff == '0);
            pm_re        = (pc_ff != '0);
            pm_raddr     = '0;
            rsp_valid_in = 1'b1;
            state_in     = S_EOUT;
         end

         S_EOUT: begin
            if (rsp_take) begin
               if (rsp_is_last) begin
                  rsp_valid_in = 1'b0;
                  state_in     = S_IDLE;
               end else begin
                  // next entry lands in pm_rd_ff at the same edge
                  pm_re    = 1'b1;
                  pm_raddr = k_ff + PAW'(1);
                  k_in     = k_ff + PAW'(1);
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      pi_ff       <= pi_in;
      cj_ff       <= cj_in;
      req_ff      <= req_in;
      rest_ff     <= rest_in;
      back_ff     <= back_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      vsrc_ff     <= vsrc_in;
      cnt_ff      <= cnt_in;
      wpend_ff    <= wpend_in;
      k_ff        <= k_in;
      spliced_ff  <= spliced_in;
      empty_ff    <= empty_in;
      drop_rpt_ff <= drop_rpt_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         vc_ff        <= '0;
         drop_ff      <= 1'b0;
         limit_ff     <= PATH_LIMIT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         vc_ff        <= vc_in;
         drop_ff      <= drop_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result port: the path RAM read register doubles as the output entry register
   // ---------------------------------------------------------------------------------------
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_ref   = empty_ff ? '0 : REF_PORT_W'(pm_rd_ff);
   assign rsp_entry_index = INDEX_W'(k_ff);
   assign rsp_path_length = LEN_W'(pc_ff);
   assign rsp_spliced     = spliced_ff;
   assign rsp_empty_path  = empty_ff;
   assign rsp_dropped     = drop_rpt_ff;
   assign rsp_last        = rsp_is_last;

endmodule

// ===== rtl/pcs_check.sv =====
// Port checker for the path corridor splice block, with its bind.
`timescale 1ns / 1ps

module pcs_check (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [pcs_pkg::REF_PORT_W-1:0]   rsp_entry_ref,
   input logic [pcs_pkg::INDEX_W-1:0]      rsp_entry_index,
   input logic [pcs_pkg::LEN_W-1:0]        rsp_path_length,
   input logic                             rsp_empty_path,
   input logic                             rsp_last
);
   import pcs_pkg::*;

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_entry_ref)
                                 && $stable(rsp_entry_index) && $stable(rsp_last))
      else $error("stalled result changed");

   // no new item is taken while a splice is still emitting
   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open during emit");

   // entries of one splice follow back to back in index order
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_valid && (rsp_entry_index == INDEX_W'($past(rsp_entry_index) + 1'b1)))
      else $error("entry index did not step");

   // an empty path is a single final item
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_path |->
         rsp_last && (rsp_path_length == '0) && (rsp_entry_index == '0))
      else $error("bad empty path item");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_empty_path |-> (LEN_W'(rsp_entry_index) < rsp_path_length))
      else $error("entry index beyond path length");

endmodule

bind path_corridor_splice pcs_check u_pcs_check (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_entry_ref   (rsp_entry_ref),
   .rsp_entry_index (rsp_entry_index),
   .rsp_path_length (rsp_path_length),
   .rsp_empty_path  (rsp_empty_path),
   .rsp_last        (rsp_last)
);
